// ----- rtl/cwc_pkg.sv -----
// Shared types and constants for the character display-width classifier.
// Holds the operation codes, width codes, register indexes and the item that
// travels down the search pipeline. No dependencies.
package cwc_pkg;

   // Field widths
   localparam int CP_W    = 21;
   localparam int IDX_W   = 9;
   localparam int COUNT_W = 10;
   localparam int WIDTH_W = 3;
   localparam int ENTRY_W = 2 * CP_W;

   // Default table depth
   localparam int MAX_RANGES_DEFAULT = 512;

   // Operation codes
   typedef enum logic [1:0] {
      OP_CLASSIFY   = 2'd0,
      OP_WRITE_ZERO = 2'd1,
      OP_WRITE_WIDE = 2'd2
   } op_type;

   // Register indexes on the csr port
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_COUNT = 1'b1;

   // Display width codes, two's complement
   localparam logic [WIDTH_W-1:0] WIDTH_CONTROL = 3'b111;
   localparam logic [WIDTH_W-1:0] WIDTH_ZERO    = 3'b000;
   localparam logic [WIDTH_W-1:0] WIDTH_NARROW  = 3'b001;
   localparam logic [WIDTH_W-1:0] WIDTH_WIDE    = 3'b010;

   // Control character boundaries
   localparam logic [CP_W-1:0] CP_C0_END = 21'h00020;
   localparam logic [CP_W-1:0] CP_DEL    = 21'h0007F;
   localparam logic [CP_W-1:0] CP_C1_END = 21'h000A0;

   // Item carried through every search level
   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    entry_index;
      logic [CP_W-1:0]     range_first;
      logic [CP_W-1:0]     range_last;
      logic [CP_W-1:0]     code_point;
      logic                fixed_hit;    // null or control, no table search
      logic [WIDTH_W-1:0]  fixed_width;
      logic                zero_found;
      logic                wide_found;
   } item_type;

endpackage

// ----- rtl/cwc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cwc_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cwc_level.sv -----
// One level of the pipelined binary search over both range tables.
// Each level keeps its own copy of both tables. Depends on cwc_pkg, cwc_ram.
module cwc_level
   import cwc_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT,
   localparam int CW = $clog2(MAX_RANGES + 1),
   localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  item_type      in_item,
   input  logic [CW-1:0] in_zlo,
   input  logic [CW-1:0] in_zhi,
   input  logic [CW-1:0] in_wlo,
   input  logic [CW-1:0] in_whi,
   output logic          out_valid,
   output item_type      out_item,
   output logic [CW-1:0] out_zlo,
   output logic [CW-1:0] out_zhi,
   output logic [CW-1:0] out_wlo,
   output logic [CW-1:0] out_whi
);

   logic          z_act;
   logic          w_act;
   logic [CW-1:0] z_mid;
   logic [CW-1:0] w_mid;
   logic          z_we;
   logic          w_we;
   logic [AW-1:0] z_addr;
   logic [AW-1:0] w_addr;
   logic [AW-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] z_rdata;
   logic [ENTRY_W-1:0] w_rdata;

   logic          valid_a_ff;
   item_type      item_a_ff;
   logic [CW-1:0] zlo_a_ff, zhi_a_ff, zmid_a_ff;
   logic [CW-1:0] wlo_a_ff, whi_a_ff, wmid_a_ff;
   logic          zact_a_ff, wact_a_ff;

   item_type      item_b_in;
   logic [CW-1:0] zlo_b_in, zhi_b_in, wlo_b_in, whi_b_in;

   logic          valid_b_ff;
   item_type      item_b_ff;
   logic [CW-1:0] zlo_b_ff, zhi_b_ff, wlo_b_ff, whi_b_ff;

   // Probe address: lo + (hi - lo) / 2, only while the window is open
   assign z_mid = in_zlo + ((in_zhi - in_zlo) >> 1);
   assign w_mid = in_wlo + ((in_whi - in_wlo) >> 1);

   assign z_act = in_valid && (in_item.op == OP_CLASSIFY) && !in_item.fixed_hit &&
                  !in_item.zero_found && (in_zlo < in_zhi);
   assign w_act = in_valid && (in_item.op == OP_CLASSIFY) && !in_item.fixed_hit &&
                  !in_item.zero_found && !in_item.wide_found && (in_wlo < in_whi);

   // Table loads are applied when the load reaches this level, keeping order
   assign z_we    = advance && in_valid && (in_item.op == OP_WRITE_ZERO);
   assign w_we    = advance && in_valid && (in_item.op == OP_WRITE_WIDE);
   assign wr_addr = AW'(in_item.entry_index);
   assign wr_data = {in_item.range_first, in_item.range_last};
   assign z_addr  = AW'(z_mid);
   assign w_addr  = AW'(w_mid);

   cwc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_zero_ram (
      .clock   (clock),
      .wr_en   (z_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance && z_act),
      .rd_addr (z_addr),
      .rd_data (z_rdata)
   );

   cwc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_wide_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance && w_act),
      .rd_addr (w_addr),
      .rd_data (w_rdata)
   );

   // Read stage: window and probe index wait for the RAM data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_a_ff <= in_item;
         zlo_a_ff  <= in_zlo;
         zhi_a_ff  <= in_zhi;
         zmid_a_ff <= z_mid;
         zact_a_ff <= z_act;
         wlo_a_ff  <= in_wlo;
         whi_a_ff  <= in_whi;
         wmid_a_ff <= w_mid;
         wact_a_ff <= w_act;
      end
   end

   // Compare stage: narrow the window or mark a hit
   always_comb begin
      item_b_in = item_a_ff;
      zlo_b_in  = zlo_a_ff;
      zhi_b_in  = zhi_a_ff;
      wlo_b_in  = wlo_a_ff;
      whi_b_in  = whi_a_ff;
      if (zact_a_ff) begin
         if (item_a_ff.code_point > z_rdata[CP_W-1:0]) begin
            zlo_b_in = zmid_a_ff + CW'(1);
         end else if (item_a_ff.code_point < z_rdata[ENTRY_W-1:CP_W]) begin
            zhi_b_in = zmid_a_ff;
         end else begin
            item_b_in.zero_found = 1'b1;
         end
      end
      if (wact_a_ff) begin
         if (item_a_ff.code_point > w_rdata[CP_W-1:0]) begin
            wlo_b_in = wmid_a_ff + CW'(1);
         end else if (item_a_ff.code_point < w_rdata[ENTRY_W-1:CP_W]) begin
            whi_b_in = wmid_a_ff;
         end else begin
            item_b_in.wide_found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_b_ff <= item_b_in;
         zlo_b_ff  <= zlo_b_in;
         zhi_b_ff  <= zhi_b_in;
         wlo_b_ff  <= wlo_b_in;
         whi_b_ff  <= whi_b_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_item  = item_b_ff;
   assign out_zlo   = zlo_b_ff;
   assign out_zhi   = zhi_b_ff;
   assign out_wlo   = wlo_b_ff;
   assign out_whi   = whi_b_ff;

   // Search window never inverts
   a_zero_window: assert property (@(posedge clock) disable iff (reset)
      (valid_b_ff && item_b_ff.op == OP_CLASSIFY) |-> (zlo_b_ff <= zhi_b_ff))
      else $error("zero-width search window inverted");

   a_wide_window: assert property (@(posedge clock) disable iff (reset)
      (valid_b_ff && item_b_ff.op == OP_CLASSIFY) |-> (wlo_b_ff <= whi_b_ff))
      else $error("wide search window inverted");

   // A hit is only ever found inside an open window
   a_hit_in_window: assert property (@(posedge clock) disable iff (reset)
      (valid_b_ff && item_b_ff.op == OP_CLASSIFY && item_b_ff.zero_found &&
       !item_b_ff.fixed_hit) |-> (zlo_b_ff < zhi_b_ff))
      else $error("zero-width hit outside search window");

endmodule

// ----- rtl/unicode_char_width_classifier_top.sv -----
// Top level of the character display-width classifier: input stage, chain of
// search levels, output register with skid. Depends on cwc_pkg, cwc_level.
//
// Usage:
//   req channel carries one item per transfer: a classify (code_point) or a
//   load of one range entry (entry_index, range_first, range_last) into the
//   zero-width or wide table. Loads give no result; classifies give one
//   rsp transfer with display_width (-1, 0, 1 or 2), in request order.
//   csr port sets the number of valid entries of each table; write it only
//   while the block is idle.
//   Throughput: one item per cycle while req_stall is low. Each search level owns a
//   copy of both tables and reads each at most once per item, so levels = clog2(MAX_RANGES + 1).
//   Path: the input stage loads at the transfer edge, then each level has a RAM
//   read stage and a compare stage, and the output register drives rsp_valid.
//   Reset: clears all valid bits and both counts. Table contents are
//   undefined until loaded; no clearing pass is run.
//   Stall: when rsp_stall holds a result, the next result parks in a skid
//   register; req_stall rises only once the skid register is full, and the
//   whole pipeline then holds until the receiver takes a result.
module unicode_char_width_classifier_top
   import cwc_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_operation,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic [CP_W-1:0]         req_range_first,
   input  logic [CP_W-1:0]         req_range_last,
   input  logic [CP_W-1:0]         req_code_point,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [WIDTH_W-1:0] rsp_display_width,
   // register write port
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [COUNT_W-1:0]      csr_wdata
);

   localparam int LEVELS = $clog2(MAX_RANGES + 1);
   localparam int CW     = LEVELS;

   logic [COUNT_W-1:0] zero_len_ff;
   logic [COUNT_W-1:0] wide_len_ff;

   logic          advance;
   logic          keep;
   logic          idx_ok;
   item_type      s0_item_in;
   logic [CW-1:0] zero_hi;
   logic [CW-1:0] wide_hi;

   logic          s0_valid_ff;
   item_type      s0_item_ff;
   logic [CW-1:0] s0_zhi_ff;
   logic [CW-1:0] s0_whi_ff;

   logic            lv_valid [LEVELS+1];
   item_type        lv_item [LEVELS+1];
   logic [CW-1:0]   lv_zlo [LEVELS+1];
   logic [CW-1:0]   lv_zhi [LEVELS+1];
   logic [CW-1:0]   lv_wlo [LEVELS+1];
   logic [CW-1:0]   lv_whi [LEVELS+1];

   logic               exit_valid;
   logic [WIDTH_W-1:0] exit_width;

   logic               out_valid_in, out_valid_ff;
   logic [WIDTH_W-1:0] out_width_in, out_width_ff;
   logic               skid_valid_in, skid_valid_ff;
   logic [WIDTH_W-1:0] skid_width_in, skid_width_ff;

   // Count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_len_ff <= '0;
         wide_len_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ZERO_COUNT: zero_len_ff <= csr_wdata;
            CSR_WIDE_COUNT: wide_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline moves whenever the skid register is free
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Input decode: drop unused codes and out-of-range loads, flag null and controls
   always_comb begin
      idx_ok = (32'(req_entry_index) < MAX_RANGES);
      keep   = (req_operation == OP_CLASSIFY) ||
               (((req_operation == OP_WRITE_ZERO) || (req_operation == OP_WRITE_WIDE)) &&
                idx_ok);

      s0_item_in.op          = op_type'(req_operation);
      s0_item_in.entry_index = req_entry_index;
      s0_item_in.range_first = req_range_first;
      s0_item_in.range_last  = req_range_last;
      s0_item_in.code_point  = req_code_point;
      s0_item_in.zero_found  = 1'b0;
      s0_item_in.wide_found  = 1'b0;
      if (req_code_point == '0) begin
         s0_item_in.fixed_hit   = 1'b1;
         s0_item_in.fixed_width = WIDTH_ZERO;
      end else if ((req_code_point < CP_C0_END) ||
                   ((req_code_point >= CP_DEL) && (req_code_point < CP_C1_END))) begin
         s0_item_in.fixed_hit   = 1'b1;
         s0_item_in.fixed_width = WIDTH_CONTROL;
      end else begin
         s0_item_in.fixed_hit   = 1'b0;
         s0_item_in.fixed_width = WIDTH_NARROW;
      end

      // Search upper bounds, saturated at the table depth
      zero_hi = (32'(zero_len_ff) > MAX_RANGES) ? CW'(MAX_RANGES) : CW'(zero_len_ff);
      wide_hi = (32'(wide_len_ff) > MAX_RANGES) ? CW'(MAX_RANGES) : CW'(wide_len_ff);
   end

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_item_ff <= s0_item_in;
         s0_zhi_ff  <= zero_hi;
         s0_whi_ff  <= wide_hi;
      end
   end

   assign lv_valid[0] = s0_valid_ff;
   assign lv_item[0]  = s0_item_ff;
   assign lv_zlo[0]   = '0;
   assign lv_zhi[0]   = s0_zhi_ff;
   assign lv_wlo[0]   = '0;
   assign lv_whi[0]   = s0_whi_ff;

   // Search levels
   for (genvar k = 0; k < LEVELS; k++) begin : g_level
      cwc_level #(.MAX_RANGES(MAX_RANGES)) u_level (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (lv_valid[k]),
         .in_item   (lv_item[k]),
         .in_zlo    (lv_zlo[k]),
         .in_zhi    (lv_zhi[k]),
         .in_wlo    (lv_wlo[k]),
         .in_whi    (lv_whi[k]),
         .out_valid (lv_valid[k+1]),
         .out_item  (lv_item[k+1]),
         .out_zlo   (lv_zlo[k+1]),
         .out_zhi   (lv_zhi[k+1]),
         .out_wlo   (lv_wlo[k+1]),
         .out_whi   (lv_whi[k+1])
      );
   end

   // Final width pick: null and controls, then zero-width table, then wide table
   always_comb begin
      exit_valid = advance && lv_valid[LEVELS] && (lv_item[LEVELS].op == OP_CLASSIFY);
      if (lv_item[LEVELS].fixed_hit) begin
         exit_width = lv_item[LEVELS].fixed_width;
      end else if (lv_item[LEVELS].zero_found) begin
         exit_width = WIDTH_ZERO;
      end else if (lv_item[LEVELS].wide_found) begin
         exit_width = WIDTH_WIDE;
      end else begin
         exit_width = WIDTH_NARROW;
      end
   end

   // Output register with skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_width_in  = out_width_ff;
      skid_valid_in = skid_valid_ff;
      skid_width_in = skid_width_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_width_in  = skid_width_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = exit_valid;
            out_width_in = exit_width;
         end
      end else if (exit_valid) begin
         skid_valid_in = 1'b1;
         skid_width_in = exit_width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_width_ff  <= out_width_in;
      skid_width_ff <= skid_width_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_display_width = $signed(out_width_ff);

   // Skid holds a result only behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full with empty output");

   // Skid fills only when the receiver held the output
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   // A taken output is refilled from the skid at once
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_stall && skid_valid_ff) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid not drained after transfer");

endmodule

// ----- tb/cwc_width_checker.sv -----
`timescale 1ns / 1ps
// Checker for the character display-width classifier. It watches the request,
// response and register ports, predicts each width and compares in order.
// Depends on cwc_pkg.
module cwc_width_checker
   import cwc_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [1:0]               req_operation,
   input  logic [IDX_W-1:0]         req_entry_index,
   input  logic [CP_W-1:0]          req_range_first,
   input  logic [CP_W-1:0]          req_range_last,
   input  logic [CP_W-1:0]          req_code_point,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [WIDTH_W-1:0] rsp_display_width,
   input  logic                     csr_write,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [COUNT_W-1:0]       csr_wdata,
   output int                       mismatches,
   output int                       outstanding,
   output int                       n_control,
   output int                       n_zero,
   output int                       n_narrow,
   output int                       n_wide
);

   typedef struct packed {
      logic [CP_W-1:0] first;
      logic [CP_W-1:0] last;
   } span_type;

   typedef struct {
      logic [CP_W-1:0]           code_point;
      logic signed [WIDTH_W-1:0] width;
   } width_exp_type;

   // Shadow copy of both range tables and their counts
   span_type           zero_spans [MAX_RANGES];
   span_type           wide_spans [MAX_RANGES];
   logic [COUNT_W-1:0] zero_len;
   logic [COUNT_W-1:0] wide_len;

   width_exp_type expected_widths [$];
   width_exp_type oldest;
   width_exp_type fresh;

   // Binary search over the valid part of one table; count saturates at depth
   function automatic logic span_hit(input logic use_wide, input logic [CP_W-1:0] cp);
      int       lo;
      int       hi;
      int       mid;
      span_type probe;
      lo = 0;
      hi = use_wide ? int'(wide_len) : int'(zero_len);
      if (hi > MAX_RANGES) hi = MAX_RANGES;
      while (lo < hi) begin
         mid   = lo + (hi - lo) / 2;
         probe = use_wide ? wide_spans[mid] : zero_spans[mid];
         if (cp > probe.last) lo = mid + 1;
         else if (cp < probe.first) hi = mid;
         else return 1'b1;
      end
      return 1'b0;
   endfunction

   // Null first, then controls, then zero-width table, then wide table
   function automatic logic signed [WIDTH_W-1:0] predict_width(input logic [CP_W-1:0] cp);
      if (cp == '0) return WIDTH_ZERO;
      if (cp < CP_C0_END || (cp >= CP_DEL && cp < CP_C1_END)) return WIDTH_CONTROL;
      if (span_hit(1'b0, cp)) return WIDTH_ZERO;
      if (span_hit(1'b1, cp)) return WIDTH_WIDE;
      return WIDTH_NARROW;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_widths.delete();
         zero_len    = '0;
         wide_len    = '0;
         outstanding <= 0;
      end else begin
         // result transfer: compare with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_widths.size() == 0) begin
               $display("%0t: unexpected display_width: expected none, actual %0d",
                        $time, rsp_display_width);
               mismatches <= mismatches + 1;
            end else begin
               oldest = expected_widths.pop_front();
               if (rsp_display_width !== oldest.width) begin
                  $display("%0t: display_width for 0x%06h: expected %0d, actual %0d",
                           $time, oldest.code_point, oldest.width, rsp_display_width);
                  mismatches <= mismatches + 1;
               end
            end
            case (rsp_display_width)
               WIDTH_CONTROL: n_control <= n_control + 1;
               WIDTH_ZERO:    n_zero    <= n_zero + 1;
               WIDTH_NARROW:  n_narrow  <= n_narrow + 1;
               WIDTH_WIDE:    n_wide    <= n_wide + 1;
               default: ;
            endcase
         end

         // count register writes
         if (csr_write) begin
            case (csr_index)
               CSR_ZERO_COUNT: zero_len = csr_wdata;
               CSR_WIDE_COUNT: wide_len = csr_wdata;
               default: ;
            endcase
         end

         // request transfer: classify predicts, loads update the tables
         if (req_valid && !req_stall) begin
            case (req_operation)
               OP_CLASSIFY: begin
                  fresh.code_point = req_code_point;
                  fresh.width      = predict_width(req_code_point);
                  expected_widths.push_back(fresh);
               end
               OP_WRITE_ZERO: begin
                  if (int'(req_entry_index) < MAX_RANGES) begin
                     zero_spans[req_entry_index].first = req_range_first;
                     zero_spans[req_entry_index].last  = req_range_last;
                  end
               end
               OP_WRITE_WIDE: begin
                  if (int'(req_entry_index) < MAX_RANGES) begin
                     wide_spans[req_entry_index].first = req_range_first;
                     wide_spans[req_entry_index].last  = req_range_last;
                  end
               end
               default: ; // unused code changes nothing
            endcase
         end

         outstanding <= expected_widths.size();
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the character display-width classifier: clock, reset,
// request and register stimulus, response stalls and the verdict.
// Depends on cwc_pkg, unicode_char_width_classifier_top and cwc_width_checker.
module tb;
   import cwc_pkg::*;

   localparam int         MAX_RANGES    = MAX_RANGES_DEFAULT;
   localparam int         LATENCY       = 21;
   localparam int         SETTLE        = 2 * LATENCY;
   localparam int         SPAN_STRIDE   = 4096;        // one slot's share of code space
   localparam int         WIDE_FILL     = 32;          // wide slots loaded and searched
   localparam int         WIDE_STRIDE   = SPAN_STRIDE * (MAX_RANGES / WIDE_FILL);
   localparam int         PHASES        = 8;
   localparam int         PHASE_ITEMS   = 16;
   localparam int         SQUEEZE_ITEMS = 48;
   localparam int         SQUEEZE_PHASE = 3;
   localparam int         HOLD_CYCLES   = 300;
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_operation;
   logic [IDX_W-1:0]          req_entry_index;
   logic [CP_W-1:0]           req_range_first;
   logic [CP_W-1:0]           req_range_last;
   logic [CP_W-1:0]           req_code_point;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [WIDTH_W-1:0] rsp_display_width;
   logic                      csr_write;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [COUNT_W-1:0]        csr_wdata;

   int mismatches;
   int outstanding;
   int n_control;
   int n_zero;
   int n_narrow;
   int n_wide;

   // What the stimulus has loaded, used to aim code points at range edges
   logic [CP_W-1:0] zero_first [MAX_RANGES];
   logic [CP_W-1:0] zero_last  [MAX_RANGES];
   logic [CP_W-1:0] wide_first [MAX_RANGES];
   logic [CP_W-1:0] wide_last  [MAX_RANGES];

   int load_total;
   int setting_total;
   int burst_left;
   bit gapless;
   bit squeeze_req;

   unicode_char_width_classifier_top #(.MAX_RANGES(MAX_RANGES)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_range_first   (req_range_first),
      .req_range_last    (req_range_last),
      .req_code_point    (req_code_point),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_display_width (rsp_display_width),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   cwc_width_checker #(.MAX_RANGES(MAX_RANGES)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_range_first   (req_range_first),
      .req_range_last    (req_range_last),
      .req_code_point    (req_code_point),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_display_width (rsp_display_width),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .n_control         (n_control),
      .n_zero            (n_zero),
      .n_narrow          (n_narrow),
      .n_wide            (n_wide)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit: ~700 items, with a wide margin for stalls
   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding", outstanding);
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver: stall pattern switches among four random modes; one long hold
   initial begin : rsp_side
      int mode;
      int mode_left;
      int hold_left;
      bit held;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      held      = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_req && !held && req_valid) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 9) < 3);
               2:       rsp_stall <= (mode_left % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   // Burst bookkeeping after each transfer: random gap once a burst runs out
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = gapless ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // One request transfer; payload holds while stalled
   task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [CP_W-1:0] first, input logic [CP_W-1:0] last,
                            input logic [CP_W-1:0] cp);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_index <= idx;
      req_range_first <= first;
      req_range_last  <= last;
      req_code_point  <= cp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_WRITE_ZERO) begin
         zero_first[idx] = first;
         zero_last[idx]  = last;
         load_total++;
      end else if (op == OP_WRITE_WIDE) begin
         wide_first[idx] = first;
         wide_last[idx]  = last;
         load_total++;
      end
      pace();
   endtask

   task automatic classify(input logic [CP_W-1:0] cp);
      send_item(OP_CLASSIFY, IDX_W'($urandom), CP_W'($urandom), CP_W'($urandom), cp);
   endtask

   task automatic load_span(input bit use_wide, input int slot,
                            input logic [CP_W-1:0] first, input logic [CP_W-1:0] last);
      send_item(use_wide ? OP_WRITE_WIDE : OP_WRITE_ZERO, IDX_W'(slot), first, last,
                CP_W'($urandom));
   endtask

   // Sorted layout: each slot owns one stride; wide spans sit partly over zero spans
   task automatic load_sorted(input bit use_wide, input int slot);
      logic [CP_W-1:0] base;
      logic [CP_W-1:0] first;
      logic [CP_W-1:0] last;
      if (use_wide) base = CP_W'(slot * WIDE_STRIDE);
      else base = CP_W'(slot * SPAN_STRIDE);
      if (use_wide) first = base + CP_W'($urandom_range(1000, 2500));
      else first = base + CP_W'($urandom_range(0, 1500));
      if (!use_wide && slot == 0) first = '0;
      if ($urandom_range(0, 7) == 0) last = first;
      else last = first + CP_W'($urandom_range(0, 1500));
      if (use_wide && slot == WIDE_FILL - 1) last = '1;
      load_span(use_wide, slot, first, last);
   endtask

   // Code points aimed at range edges, controls and the ends of code space
   function automatic logic [CP_W-1:0] pick_code_point();
      int              slot;
      logic [CP_W-1:0] first;
      logic [CP_W-1:0] last;
      if ($urandom_range(0, 1) == 1) begin
         slot  = $urandom_range(0, WIDE_FILL - 1);
         first = wide_first[slot];
         last  = wide_last[slot];
      end else begin
         slot  = $urandom_range(0, MAX_RANGES - 1);
         first = zero_first[slot];
         last  = zero_last[slot];
      end
      case ($urandom_range(0, 9))
         0: return CP_W'($urandom_range(0, CP_C1_END));
         1, 2, 3, 4, 5: begin
            case ($urandom_range(0, 4))
               0:       return first - CP_W'(1);
               1:       return first;
               2:       return last;
               3:       return last + CP_W'(1);
               default: return first + ((last - first) >> 1);
            endcase
         end
         6: begin
            case ($urandom_range(0, 4))
               0:       return '1;
               1:       return CP_W'(1);
               2:       return CP_C0_END;
               3:       return CP_DEL - CP_W'(1);
               default: return CP_C1_END - CP_W'(1);
            endcase
         end
         default: return CP_W'($urandom);
      endcase
   endfunction

   // Mostly classifies and sorted reloads; some unsorted or inverted spans and
   // unused codes, which do not count as items
   task automatic random_item(output bit counted);
      int roll;
      int slot;
      bit use_wide;
      roll     = $urandom_range(0, 99);
      use_wide = ($urandom_range(0, 1) == 1);
      if (use_wide) slot = $urandom_range(0, WIDE_FILL - 1);
      else slot = $urandom_range(0, MAX_RANGES - 1);
      counted = 1'b1;
      if (roll < 75) begin
         classify(pick_code_point());
      end else if (roll < 90) begin
         load_sorted(use_wide, slot);
      end else if (roll < 95) begin
         load_span(use_wide, slot, CP_W'($urandom), CP_W'($urandom));
      end else begin
         send_item(OP_UNUSED, IDX_W'($urandom), CP_W'($urandom), CP_W'($urandom),
                   CP_W'($urandom));
         counted = 1'b0;
      end
   endtask

   // Wait for every result, then for loads still in flight
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Both count registers, only while idle
   task automatic set_counts(input int zero_n, input int wide_n);
      csr_write <= 1'b1;
      csr_index <= CSR_ZERO_COUNT;
      csr_wdata <= COUNT_W'(zero_n);
      @(posedge clock);
      csr_index <= CSR_WIDE_COUNT;
      csr_wdata <= COUNT_W'(wide_n);
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      setting_total++;
   endtask

   initial begin : stimulus
      logic [CP_W-1:0] fixed_points [9];
      int              zero_choice  [PHASES];
      int              wide_choice  [PHASES];
      int              zero_n;
      int              wide_n;
      int              sent;
      bit              counted;

      fixed_points = '{21'h0, 21'h1, 21'h1F, 21'h20, 21'h7E, 21'h7F, 21'h9F, 21'hA0,
                       21'h1FFFFF};
      // zero counts above the table depth saturate; wide counts stay within the
      // loaded wide slots; negative means random
      zero_choice  = '{512, 1, 0, 700, 3, 1023, -1, 511};
      wide_choice  = '{32, 0, 1, 2, -1, 32, 17, 31};

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= OP_CLASSIFY;
      req_entry_index <= '0;
      req_range_first <= '0;
      req_range_last  <= '0;
      req_code_point  <= '0;
      csr_write       <= 1'b0;
      csr_index       <= CSR_ZERO_COUNT;
      csr_wdata       <= '0;
      load_total      = 0;
      setting_total   = 0;
      burst_left      = 0;
      gapless         = 1'b0;
      squeeze_req     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty tables: null, control boundaries, top of code space, unused code
      foreach (fixed_points[i]) classify(fixed_points[i]);
      send_item(OP_UNUSED, '1, '1, '1, 21'h41);

      // Fill every zero-width slot and the first wide slots with sorted spans
      for (int slot = 0; slot < MAX_RANGES; slot++) begin
         load_sorted(1'b0, slot);
         if (slot < WIDE_FILL) load_sorted(1'b1, slot);
      end
      drain();
      set_counts(MAX_RANGES, WIDE_FILL);

      // Full tables: span edges, zero-width priority, top wide span
      classify(zero_first[5]);
      classify(zero_last[5]);
      classify(zero_first[5] - CP_W'(1));
      classify(zero_last[5] + CP_W'(1));
      classify(wide_first[7]);
      classify(wide_last[7]);
      classify(wide_last[7] + CP_W'(1));
      classify(wide_first[3]);
      classify(21'h1FFFFF);
      drain();

      // Random phases over a spread of count settings
      for (int phase = 0; phase < PHASES; phase++) begin
         zero_n = (zero_choice[phase] < 0) ? $urandom_range(0, 1023) : zero_choice[phase];
         wide_n = (wide_choice[phase] < 0) ? $urandom_range(0, WIDE_FILL) : wide_choice[phase];
         set_counts(zero_n, wide_n);
         squeeze_req = (phase == SQUEEZE_PHASE);
         gapless     = squeeze_req;
         sent        = 0;
         while (sent < ((phase == SQUEEZE_PHASE) ? SQUEEZE_ITEMS : PHASE_ITEMS)) begin
            random_item(counted);
            sent += counted;
         end
         drain();
         squeeze_req = 1'b0;
         gapless     = 1'b0;
      end

      $display("Covered %0d table loads and %0d classifications (%0d control, %0d zero,",
               load_total, n_control + n_zero + n_narrow + n_wide, n_control, n_zero);
      $display("%0d narrow, %0d wide) over %0d count settings, with one long output hold.",
               n_narrow, n_wide, setting_total);
      if (mismatches == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/cwc_pkg.sv
rtl/cwc_ram.sv
rtl/cwc_level.sv
rtl/unicode_char_width_classifier_top.sv
tb/cwc_width_checker.sv
tb/tb.sv
